### rtl/crt_pfu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_pfu_pkg
// Shared types, constants and channel helpers for the phosphor frame update.
// ----------------------------------------------------------------------------
package crt_pfu_pkg;

  localparam int FRAME_PIXELS   = 65536;
  localparam int MAX_LINE_WIDTH = 1024;
  localparam int COUNT_LIMIT    = 1024;
  localparam int WIDTH_LIMIT    = (MAX_LINE_WIDTH < COUNT_LIMIT) ? MAX_LINE_WIDTH : COUNT_LIMIT;

  localparam int ADDR_W   = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int CNT_W    = 10;
  localparam int GEOM_W   = 11;
  localparam int DECAY_W  = 19;
  localparam int LIN_W    = CNT_W + GEOM_W;
  localparam int CH_W     = 6;
  localparam int PIX_W    = 22;
  localparam int TERM_W   = 7;
  localparam int PART_W   = 2 * TERM_W;
  localparam int SEEP_W   = 3 * TERM_W;
  localparam int CHARGE_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DECAY_W;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_STEP = 2'd2;

  localparam logic [GEOM_W-1:0]  LINE_WIDTH_RST = 11'd320;
  localparam logic [GEOM_W-1:0]  LINE_COUNT_RST = 11'd200;
  localparam logic [DECAY_W-1:0] DRAIN_STEP_RST = 19'd1228;

  localparam logic [CH_W-1:0] CH_MAX = 6'h3F;

  typedef struct packed {
    logic [31:0] source_colour;
    logic [1:0]  noise_level;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] phosphor_colour;
    logic             frame_end;
  } out_word_t;

  typedef struct packed {
    logic [GEOM_W-1:0]  line_width;
    logic [GEOM_W-1:0]  line_count;
    logic [DECAY_W-1:0] drain_step;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]   ch3;
    logic [CH_W-1:0]   ch2;
    logic [CH_W-1:0]   ch1;
    logic [CH_W-1:0]   ch0;
    logic [1:0]        noise;
    logic [ADDR_W-1:0] addr;
    logic              first_col;
    logic              last;
  } job_t;

  function automatic logic [CH_W-1:0] sat_add6(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    logic [CH_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CH_W] ? CH_MAX : s[CH_W-1:0];
  endfunction

  function automatic logic [CH_W-1:0] max6(input logic [CH_W-1:0] a,
                                           input logic [CH_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [GEOM_W-1:0] clamp_geom(input logic [GEOM_W-1:0] v);
    logic [GEOM_W-1:0] r;
    if (v == '0) begin
      r = GEOM_W'(1);
    end else if (v > GEOM_W'(WIDTH_LIMIT)) begin
      r = GEOM_W'(WIDTH_LIMIT);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [GEOM_W-1:0] clamp_rows(input logic [GEOM_W-1:0] v);
    logic [GEOM_W-1:0] r;
    if (v == '0) begin
      r = GEOM_W'(1);
    end else if (v > GEOM_W'(COUNT_LIMIT)) begin
      r = GEOM_W'(COUNT_LIMIT);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### rtl/crt_phosphor_frame_update_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_phosphor_frame_update_top
// Phosphor frame update: decays the stored frame and blends in new pixels.
// ----------------------------------------------------------------------------
// After reset the block clears all 65536 words of its frame store, with full
// held high; configuration writes are taken during that time. Each pixel
// word then passes through the update engine in order: a frame store read
// with the first step of the seepage product, the second step of the
// product, a blend and write-back step that waits while a finished word is
// held, and a charge decay step. Words are queued up to two deep ahead of
// the engine; one finished word is held for the consumer while the next runs.
module crt_phosphor_frame_update_top import crt_pfu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  in_word_t              in_data,
  output logic                  in_full,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;
  logic q_push, q_pop, q_full, q_empty, clearing;
  job_t q_in, q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINE_WIDTH: cfg_nxt.line_width = cfg_wdata[GEOM_W-1:0];
        CFG_LINE_COUNT: cfg_nxt.line_count = cfg_wdata[GEOM_W-1:0];
        CFG_DRAIN_STEP: cfg_nxt.drain_step = cfg_wdata[DECAY_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_width <= LINE_WIDTH_RST;
      cfg_r.line_count <= LINE_COUNT_RST;
      cfg_r.drain_step <= DRAIN_STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  crt_pfu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_push  (in_push),
    .in_data  (in_data),
    .q_full   (q_full),
    .clearing (clearing),
    .in_full  (in_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  crt_pfu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  crt_pfu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

### rtl/crt_pfu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_pfu_front
// Accepts input words, tracks the raster position and forms store jobs.
// ----------------------------------------------------------------------------
module crt_pfu_front import crt_pfu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_push,
  input  in_word_t in_data,
  input  logic     q_full,
  input  logic     clearing,
  output logic     in_full,
  output logic     q_push,
  output job_t     q_data
);

  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;
  logic [GEOM_W-1:0] width;
  logic [GEOM_W-1:0] rows;
  logic [LIN_W-1:0]  lin;
  logic              col_end;
  logic              row_end;

  assign in_full = q_full | clearing;
  assign q_push  = in_push & ~in_full;

  assign width   = clamp_geom(cfg.line_width);
  assign rows    = clamp_rows(cfg.line_count);
  assign col_end = ({1'b0, col_r} + GEOM_W'(1)) >= width;
  assign row_end = ({1'b0, row_r} + GEOM_W'(1)) >= rows;
  assign lin     = LIN_W'(row_r) * LIN_W'(width) + LIN_W'(col_r);

  always_comb begin
    q_data.ch0       = in_data.source_colour[5:0];
    q_data.ch1       = in_data.source_colour[13:8];
    q_data.ch2       = in_data.source_colour[21:16];
    q_data.ch3       = in_data.source_colour[29:24];
    q_data.noise     = in_data.noise_level;
    q_data.addr      = lin[ADDR_W-1:0];
    q_data.first_col = (col_r == '0);
    q_data.last      = col_end & row_end;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (q_push) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

### rtl/crt_pfu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_pfu_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module crt_pfu_queue import crt_pfu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head
);

  job_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + (Q_PTR_W+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (Q_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/crt_pfu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_pfu_back
// Frame store, seepage product, row charge and pixel blend, one job at a time.
// ----------------------------------------------------------------------------
module crt_pfu_back import crt_pfu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_empty,
  input  job_t      q_head,
  output logic      q_pop,
  output logic      clearing,
  output logic      out_empty,
  input  logic      out_pop,
  output out_word_t out_data
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_SUM   = 5'b01000,
    ST_DEC   = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [PIX_W-1:0]    mem [FRAME_PIXELS];
  logic [PIX_W-1:0]    rd_r;
  job_t                job_r;
  logic [PART_W-1:0]   p1_r;
  logic [TERM_W-1:0]   fc_r;
  logic [SEEP_W-1:0]   p2_r;
  logic [CHARGE_W-1:0] sum_r;
  logic [CHARGE_W-1:0] charge_r, charge_nxt;
  out_word_t           out_r;
  logic                out_valid_r, out_valid_nxt;

  logic [TERM_W-1:0]   ta, tb, tc;
  logic                start;
  logic                sum_go;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_wa;
  logic [PIX_W-1:0]    mem_wd;
  logic [CHARGE_W-1:0] base;
  logic [CH_W-1:0]     ghost;
  logic [CH_W-1:0]     cur0, cur1, cur2;
  logic [PIX_W-1:0]    res;

  assign clearing  = (state_r == ST_CLEAR);
  assign start     = (state_r == ST_IDLE) & ~q_empty;
  assign q_pop     = start;
  assign sum_go    = (state_r == ST_SUM) & (~out_valid_r | out_pop);
  assign out_empty = ~out_valid_r;
  assign out_data  = out_r;

  assign ta = TERM_W'(q_head.ch0) + TERM_W'(q_head.ch2[CH_W-1:2])
            + TERM_W'(q_head.ch3[CH_W-1:2]);
  assign tb = TERM_W'(q_head.ch2) + TERM_W'(q_head.ch0[CH_W-1:2])
            + TERM_W'(q_head.ch3[CH_W-1:2]);
  assign tc = TERM_W'(q_head.ch3) + TERM_W'(q_head.ch0[CH_W-1:2])
            + TERM_W'(q_head.ch3[CH_W-1:2]);

  assign base  = job_r.first_col ? '0 : charge_r;
  assign ghost = base[24:19];
  assign cur0  = sat_add6(sat_add6(job_r.ch0, ghost), CH_W'(job_r.noise));
  assign cur1  = sat_add6(sat_add6(job_r.ch1, ghost), CH_W'(job_r.noise));
  assign cur2  = sat_add6(sat_add6(job_r.ch2, ghost), CH_W'(job_r.noise));

  always_comb begin
    res        = '0;
    res[21:16] = max6({1'b0, rd_r[21:17]}, cur2);
    res[13:8]  = max6({1'b0, rd_r[13:9]}, cur1);
    res[5:0]   = max6({1'b0, rd_r[5:1]}, cur0);
  end

  assign mem_we = clearing | sum_go;
  assign mem_wa = clearing ? clr_cnt_r : job_r.addr;
  assign mem_wd = clearing ? '0 : res;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    charge_nxt    = charge_r;
    out_valid_nxt = out_valid_r;
    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(FRAME_PIXELS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (sum_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_DEC;
        end
      end
      ST_DEC: begin
        charge_nxt = (sum_r > CHARGE_W'(cfg.drain_step))
                   ? sum_r - CHARGE_W'(cfg.drain_step) : '0;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      charge_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      charge_r    <= charge_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      job_r <= q_head;
      p1_r  <= PART_W'(ta) * PART_W'(tb);
      fc_r  <= tc;
    end
    if (state_r == ST_MUL) begin
      p2_r <= SEEP_W'(p1_r) * SEEP_W'(fc_r);
    end
    if (sum_go) begin
      sum_r                 <= base + CHARGE_W'(p2_r);
      out_r.phosphor_colour <= res;
      out_r.frame_end       <= job_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (start) begin
      rd_r <= mem[q_head.addr];
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the phosphor frame update block against a predictor of the frame
// store, the row charge and the raster counters. Runs a directed set of
// pixels on the reset geometry, then random pixel runs under geometries
// that cover the extremes, mid-frame geometry changes and address wrap.
// ----------------------------------------------------------------------------
import crt_pfu_pkg::*;

class phosphor_scoreboard;
  bit [23:0]        frame_mem [FRAME_PIXELS];
  bit [31:0]        charge;
  int unsigned      col;
  int unsigned      row;
  bit [GEOM_W-1:0]  width_reg;
  bit [GEOM_W-1:0]  count_reg;
  bit [DECAY_W-1:0] decay_reg;
  out_word_t        pending [$];
  int               errors;

  function new();
    foreach (frame_mem[i]) frame_mem[i] = '0;
    charge    = '0;
    col       = 0;
    row       = 0;
    width_reg = LINE_WIDTH_RST;
    count_reg = LINE_COUNT_RST;
    decay_reg = DRAIN_STEP_RST;
    errors    = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_LINE_WIDTH: width_reg = data[GEOM_W-1:0];
      CFG_LINE_COUNT: count_reg = data[GEOM_W-1:0];
      CFG_DRAIN_STEP: decay_reg = data[DECAY_W-1:0];
      default: ;
    endcase
  endfunction

  static function int unsigned eff_size(bit [GEOM_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  static function bit [5:0] sat6(bit [5:0] a, bit [5:0] b);
    bit [6:0] s;
    s = a + b;
    return (s > 7'd63) ? 6'h3F : s[5:0];
  endfunction

  static function bit [31:0] seepage(bit [31:0] src);
    int unsigned r, g, b;
    r = src[5:0];
    g = src[21:16];
    b = src[29:24];
    return (r + g / 4 + b / 4) * (g + r / 4 + b / 4) * (b + r / 4 + b / 4);
  endfunction

  function void note_pixel(in_word_t w);
    int unsigned w_eff, h_eff, addr;
    bit [5:0]    ghost, oldv, curv;
    bit [23:0]   halved, resv;
    bit          last;
    out_word_t   exp_word;
    w_eff = eff_size(width_reg, WIDTH_LIMIT);
    h_eff = eff_size(count_reg, COUNT_LIMIT);
    if (col == 0) charge = '0;
    addr   = (row * w_eff + col) % FRAME_PIXELS;
    halved = frame_mem[addr] >> 1;
    ghost  = charge[24:19];
    charge = charge + seepage(w.source_colour);
    if (charge > decay_reg) charge = charge - decay_reg;
    else charge = '0;
    resv = '0;
    for (int k = 0; k < 3; k++) begin
      oldv = halved[8*k +: 6];
      curv = sat6(sat6(w.source_colour[8*k +: 6], ghost), {4'b0, w.noise_level});
      resv[8*k +: 6] = (oldv > curv) ? oldv : curv;
    end
    frame_mem[addr] = resv;
    last = 1'b0;
    if (col + 1 >= w_eff) begin
      col = 0;
      if (row + 1 >= h_eff) begin
        row  = 0;
        last = 1'b1;
      end else begin
        row++;
      end
    end else begin
      col++;
    end
    exp_word.phosphor_colour = resv[PIX_W-1:0];
    exp_word.frame_end       = last;
    pending.push_back(exp_word);
  endfunction

  function void check_result(out_word_t got);
    out_word_t exp_word;
    if (pending.size() == 0) begin
      $error("unexpected word: phosphor_colour %h frame_end %b",
             got.phosphor_colour, got.frame_end);
      errors++;
      return;
    end
    exp_word = pending.pop_front();
    if (got.phosphor_colour !== exp_word.phosphor_colour) begin
      $error("phosphor_colour expected %h actual %h",
             exp_word.phosphor_colour, got.phosphor_colour);
      errors++;
    end
    if (got.frame_end !== exp_word.frame_end) begin
      $error("frame_end expected %b actual %b", exp_word.frame_end, got.frame_end);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 300000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  in_word_t              in_data;
  logic                  in_full;
  logic                  out_empty;
  logic                  out_pop;
  out_word_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  phosphor_scoreboard sb;
  int                 idle_cycles = 0;
  bit                 steady;

  crt_phosphor_frame_update_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [31:0] pick_colour();
    int unsigned m;
    m = $urandom_range(0, 9);
    if (m < 6) return $urandom();
    if (m < 8) return $urandom() | 32'h3F3F3F3F;
    return $urandom() & 32'hC1C1C1C1;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) sb.note_pixel(in_data);
      if (out_pop && !out_empty) sb.check_result(out_data);
      if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("testbench failed");
    $finish;
  end

  initial begin
    int stall;
    int burst;
    out_pop = 1'b0;
    forever begin
      stall = pick_gap(1'b0);
      repeat (stall) @(negedge clk) out_pop = 1'b0;
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      repeat (burst) @(negedge clk) out_pop = 1'b1;
    end
  end

  task automatic send_pixel(in_word_t w);
    int gap;
    gap = pick_gap(steady);
    repeat (gap) @(negedge clk) in_push = 1'b0;
    @(negedge clk);
    in_push = 1'b1;
    in_data = w;
    do @(posedge clk); while (in_full);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] c,
                           logic [CFG_DATA_W-1:0] d, int n);
    int gap;
    wait_drained();
    gap = pick_gap(1'b0);
    repeat (gap) @(negedge clk);
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
    write_reg(CFG_LINE_WIDTH, w);
    write_reg(CFG_LINE_COUNT, c);
    write_reg(CFG_DRAIN_STEP, d);
    steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      send_pixel({pick_colour(), 2'($urandom_range(0, 3))});
    end
    @(negedge clk) in_push = 1'b0;
  endtask

  initial begin
    sb          = new();
    steady      = 1'b0;
    rst_n       = 1'b0;
    in_push     = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_LINE_WIDTH;
    cfg_wdata   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Reset geometry: channel extremes, bits outside the channels, noise clamp.
    send_pixel({32'h00000000, 2'd0});
    send_pixel({32'hFFFFFFFF, 2'd3});
    send_pixel({32'h003F3F3F, 2'd0});
    send_pixel({32'h3F3F3F3F, 2'd3});
    send_pixel({32'h3F000000, 2'd1});
    send_pixel({32'h00C0C0C0, 2'd2});
    send_pixel({32'h003E3E3E, 2'd3});
    send_pixel({32'h00010203, 2'd3});
    send_pixel({32'h80000000, 2'd0});
    send_pixel({32'h00FF00FF, 2'd1});
    send_pixel({32'h3F3F0000, 2'd2});
    send_pixel({32'h0000003F, 2'd0});
    send_pixel({32'hC0C0C0C0, 2'd3});
    send_pixel({32'h3F3F3F3F, 2'd0});
    send_pixel({32'h2A152A15, 2'd2});
    @(negedge clk) in_push = 1'b0;

    run_phase(19'd1, 19'd1024, 19'd0, 100);
    run_phase(19'd1024, 19'd1024, 19'd1228, 30);
    run_phase(19'd10, 19'd3, 19'h7FFFF, 40);
    run_phase(19'd0, 19'd0, 19'd0, 15);
    run_phase(19'd2047, 19'd2047, 19'h60000, 15);
    run_phase(19'h7F808, 19'h40004, 19'd0, 100);
    run_phase(19'd16, 19'd2, 19'($urandom_range(0, 20000)), 60);
    run_phase(19'($urandom_range(1, 40)), 19'($urandom_range(1, 8)),
              19'($urandom_range(0, 393216)), 60);

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

### sim.f
rtl/crt_pfu_pkg.sv
rtl/crt_pfu_front.sv
rtl/crt_pfu_queue.sv
rtl/crt_pfu_back.sv
rtl/crt_phosphor_frame_update_top.sv
tb/testbench.sv
